[hdl/i2cmts_pkg.sv]
package i2cmts_pkg;

  // Input item function codes
  localparam logic [1:0] FUNC_BEGIN_RD = 2'd0;
  localparam logic [1:0] FUNC_BEGIN_WR = 2'd1;
  localparam logic [1:0] FUNC_BUS_DONE = 2'd2;

  // Commands to the byte-level bus engine
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_SEND   = 3'd3;
  localparam logic [2:0] CMD_RXACK  = 3'd4;
  localparam logic [2:0] CMD_RXNACK = 3'd5;

  // Engine status codes that mean acknowledged
  localparam logic [7:0] ST_MT_SLA_ACK  = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_MR_SLA_ACK  = 8'h40;

  // Transaction error codes
  localparam logic [2:0] ERR_OK         = 3'd0;
  localparam logic [2:0] ERR_CTRLW_NACK = 3'd1;
  localparam logic [2:0] ERR_ADDRH_NACK = 3'd2;
  localparam logic [2:0] ERR_ADDRL_NACK = 3'd3;
  localparam logic [2:0] ERR_CTRLR_NACK = 3'd4;
  localparam logic [2:0] ERR_DATA_NACK  = 3'd5;

  // R/W bit of the control byte
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  typedef struct packed {
    logic [2:0] bus_cmd;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [2:0] error_code;
  } result_t;

endpackage

[hdl/i2cmts_out_reg.sv]
module i2cmts_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_valid_i,
  output logic                 load_ready_o,
  input  i2cmts_pkg::result_t  res_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output i2cmts_pkg::result_t  res_o
);

  logic                valid_q;
  i2cmts_pkg::result_t res_q;

  // The register can take a new result when empty or when its content leaves now.
  assign load_ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ready_o && load_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

[hdl/i2c_memory_transaction_sequencer_top.sv]
// Random read / page write sequencer for an I2C memory, driving a byte-level
// bus engine. Every input transfer (begin read, begin write, or bus step done)
// yields exactly one result transfer carrying the next engine command, any
// received data byte and the end-of-transaction status. Items pass through an
// input register and a result register: one item per clock is sustained while
// the output is not stalled, and each result is registered in the result register.
// The transaction phase update in the decode stage sets this rate.
// Configuration writes must only happen while no transaction is in flight.
module i2c_memory_transaction_sequencer_top #(
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [6:0]           cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [15:0]          maddr_i,
  input  logic [7:0]           length_i,
  input  logic [7:0]           wr_data_i,
  input  logic [7:0]           bus_status_i,
  input  logic [7:0]           bus_rx_byte_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           bus_cmd_o,
  output logic [7:0]           tx_byte_o,
  output logic                 rx_valid_o,
  output logic [7:0]           rx_byte_o,
  output logic                 done_res_o,
  output logic [2:0]           error_code_o
);

  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_ADDRESS_BYTES  = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_CTRLW,
    PH_ADDRH,
    PH_ADDRL,
    PH_WDATA,
    PH_RSTART,
    PH_CTRLR,
    PH_RDATA
  } phase_e;

  // configuration
  logic [6:0] dev_addr_q;
  logic [1:0] addr_bytes_q;

  // transaction state
  phase_e                 phase_q, phase_d;
  logic                   is_read_q, is_read_d;
  logic [ADDR_BITS-1:0]   target_q, target_d;
  logic [7:0]             bytes_left_q, bytes_left_d;

  // input register
  logic        s1_valid_q;
  logic [1:0]  func_q;
  logic [15:0] maddr_q;
  logic [7:0]  length_q;
  logic [7:0]  wr_data_q;
  logic [7:0]  status_q;
  logic [7:0]  rx_byte_q;

  logic                in_accept;
  logic                out_ready;
  logic                s1_fire;
  logic [15:0]         target_ext;
  logic [7:0]          bytes_dec;
  i2cmts_pkg::result_t res;
  i2cmts_pkg::result_t res_out;

  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && out_ready;
  assign target_ext = 16'(target_q);
  assign bytes_dec  = bytes_left_q - 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= 7'd80;
      addr_bytes_q <= 2'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEVICE_ADDRESS: dev_addr_q   <= cfg_wdata_i;
        CFG_ADDRESS_BYTES:  addr_bytes_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q     <= func_i;
      maddr_q    <= maddr_i;
      length_q   <= length_i;
      wr_data_q  <= wr_data_i;
      status_q   <= bus_status_i;
      rx_byte_q  <= bus_rx_byte_i;
    end
  end

  // Next command and phase for the item in the input register.
  always_comb begin
    res          = '0;
    phase_d      = phase_q;
    is_read_d    = is_read_q;
    target_d     = target_q;
    bytes_left_d = bytes_left_q;

    if (func_q == i2cmts_pkg::FUNC_BEGIN_RD || func_q == i2cmts_pkg::FUNC_BEGIN_WR) begin
      // a begin item while busy is dropped with an empty result
      if (phase_q == PH_IDLE) begin
        is_read_d    = (func_q == i2cmts_pkg::FUNC_BEGIN_RD);
        target_d     = maddr_q[ADDR_BITS-1:0];
        bytes_left_d = length_q;
        phase_d      = PH_START;
        res.bus_cmd  = i2cmts_pkg::CMD_START;
      end
    end else if (func_q == i2cmts_pkg::FUNC_BUS_DONE) begin
      case (phase_q)
        PH_IDLE: ;
        PH_START: begin
          res.bus_cmd = i2cmts_pkg::CMD_SEND;
          res.tx_byte = {dev_addr_q, i2cmts_pkg::RW_WRITE};
          phase_d     = PH_CTRLW;
        end
        PH_CTRLW: begin
          if (status_q != i2cmts_pkg::ST_MT_SLA_ACK) begin
            res.done_res   = 1'b1;
            res.error_code = i2cmts_pkg::ERR_CTRLW_NACK;
            phase_d        = PH_IDLE;
          end else if (addr_bytes_q[1]) begin
            res.bus_cmd = i2cmts_pkg::CMD_SEND;
            res.tx_byte = target_ext[15:8];
            phase_d     = PH_ADDRH;
          end else begin
            res.bus_cmd = i2cmts_pkg::CMD_SEND;
            res.tx_byte = target_ext[7:0];
            phase_d     = PH_ADDRL;
          end
        end
        PH_ADDRH: begin
          if (status_q != i2cmts_pkg::ST_MT_DATA_ACK) begin
            res.done_res   = 1'b1;
            res.error_code = i2cmts_pkg::ERR_ADDRH_NACK;
            phase_d        = PH_IDLE;
          end else begin
            res.bus_cmd = i2cmts_pkg::CMD_SEND;
            res.tx_byte = target_ext[7:0];
            phase_d     = PH_ADDRL;
          end
        end
        PH_ADDRL: begin
          if (status_q != i2cmts_pkg::ST_MT_DATA_ACK) begin
            res.done_res   = 1'b1;
            res.error_code = i2cmts_pkg::ERR_ADDRL_NACK;
            phase_d        = PH_IDLE;
          end else if (is_read_q) begin
            res.bus_cmd = i2cmts_pkg::CMD_START;
            phase_d     = PH_RSTART;
          end else if (bytes_left_q == 8'd0) begin
            res.bus_cmd  = i2cmts_pkg::CMD_STOP;
            res.done_res = 1'b1;
            phase_d      = PH_IDLE;
          end else begin
            res.bus_cmd = i2cmts_pkg::CMD_SEND;
            res.tx_byte = wr_data_q;
            phase_d     = PH_WDATA;
          end
        end
        PH_WDATA: begin
          if (status_q != i2cmts_pkg::ST_MT_DATA_ACK) begin
            res.done_res   = 1'b1;
            res.error_code = i2cmts_pkg::ERR_DATA_NACK;
            phase_d        = PH_IDLE;
          end else begin
            bytes_left_d = bytes_dec;
            if (bytes_dec == 8'd0) begin
              res.bus_cmd  = i2cmts_pkg::CMD_STOP;
              res.done_res = 1'b1;
              phase_d      = PH_IDLE;
            end else begin
              res.bus_cmd = i2cmts_pkg::CMD_SEND;
              res.tx_byte = wr_data_q;
            end
          end
        end
        PH_RSTART: begin
          res.bus_cmd = i2cmts_pkg::CMD_SEND;
          res.tx_byte = {dev_addr_q, i2cmts_pkg::RW_READ};
          phase_d     = PH_CTRLR;
        end
        PH_CTRLR: begin
          if (status_q != i2cmts_pkg::ST_MR_SLA_ACK) begin
            res.done_res   = 1'b1;
            res.error_code = i2cmts_pkg::ERR_CTRLR_NACK;
            phase_d        = PH_IDLE;
          end else if (bytes_left_q == 8'd0) begin
            res.bus_cmd  = i2cmts_pkg::CMD_STOP;
            res.done_res = 1'b1;
            phase_d      = PH_IDLE;
          end else begin
            res.bus_cmd = (bytes_left_q > 8'd1) ? i2cmts_pkg::CMD_RXACK
                                                : i2cmts_pkg::CMD_RXNACK;
            phase_d     = PH_RDATA;
          end
        end
        PH_RDATA: begin
          // receive status is not checked
          res.rx_valid = 1'b1;
          res.rx_byte  = rx_byte_q;
          bytes_left_d = bytes_dec;
          if (bytes_dec == 8'd0) begin
            res.bus_cmd  = i2cmts_pkg::CMD_STOP;
            res.done_res = 1'b1;
            phase_d      = PH_IDLE;
          end else begin
            res.bus_cmd = (bytes_dec > 8'd1) ? i2cmts_pkg::CMD_RXACK
                                             : i2cmts_pkg::CMD_RXNACK;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      is_read_q    <= 1'b0;
      target_q     <= '0;
      bytes_left_q <= 8'd0;
    end else if (s1_fire) begin
      phase_q      <= phase_d;
      is_read_q    <= is_read_d;
      target_q     <= target_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  i2cmts_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s1_valid_q),
    .load_ready_o (out_ready),
    .res_i        (res),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res_out)
  );

  assign bus_cmd_o    = res_out.bus_cmd;
  assign tx_byte_o    = res_out.tx_byte;
  assign rx_valid_o   = res_out.rx_valid;
  assign rx_byte_o    = res_out.rx_byte;
  assign done_res_o   = res_out.done_res;
  assign error_code_o = res_out.error_code;

  // A finished transaction leaves the sequencer idle for the next item.
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && res.done_res |=> phase_q == PH_IDLE)
    else $error("phase not idle after transaction end");

  // Received data only rides with a receive or the closing stop.
  a_rx_with_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_valid_o |->
      bus_cmd_o == i2cmts_pkg::CMD_RXACK || bus_cmd_o == i2cmts_pkg::CMD_RXNACK ||
      bus_cmd_o == i2cmts_pkg::CMD_STOP)
    else $error("rx data without receive or stop");

  // An error ends the transaction with no bus command.
  a_error_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != i2cmts_pkg::ERR_OK |->
      done_res_o && bus_cmd_o == i2cmts_pkg::CMD_NONE)
    else $error("error result carries a command");

endmodule

[verif/i2c_memory_transaction_sequencer_top_tb.sv]
module i2c_memory_transaction_sequencer_top_tb;

  localparam int ADDR_BITS = 16;
  localparam logic [15:0] ADDR_MASK = 16'((1 << ADDR_BITS) - 1);

  localparam logic       REG_DEVICE_ADDRESS = 1'b0;
  localparam logic       REG_ADDRESS_BYTES  = 1'b1;
  localparam logic [1:0] FUNC_UNUSED        = 2'd3;

  localparam int NO_ERROR       = -1;
  localparam int PICK_ERROR     = -2;
  localparam int PHASE_ITEMS    = 255;
  localparam int PRESSURE_AT    = 300;
  localparam int PRESSURE_LEN   = 150;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START, SEQ_CTRLW, SEQ_ADDRH, SEQ_ADDRL,
    SEQ_WDATA, SEQ_RSTART, SEQ_CTRLR, SEQ_RDATA
  } seq_phase_e;

  typedef struct {
    logic [1:0]  func;
    logic [15:0] maddr;
    logic [7:0]  length;
    logic [7:0]  wr_data;
    logic [7:0]  bus_status;
    logic [7:0]  bus_rx_byte;
  } bus_item_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [6:0]  cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i        = '0;
  logic [15:0] maddr_i       = '0;
  logic [7:0]  length_i      = '0;
  logic [7:0]  wr_data_i     = '0;
  logic [7:0]  bus_status_i  = '0;
  logic [7:0]  bus_rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [2:0]  bus_cmd_o;
  logic [7:0]  tx_byte_o;
  logic        rx_valid_o;
  logic [7:0]  rx_byte_o;
  logic        done_res_o;
  logic [2:0]  error_code_o;

  i2c_memory_transaction_sequencer_top #(
    .ADDR_BITS(ADDR_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .maddr_i      (maddr_i),
    .length_i     (length_i),
    .wr_data_i    (wr_data_i),
    .bus_status_i (bus_status_i),
    .bus_rx_byte_i(bus_rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .bus_cmd_o    (bus_cmd_o),
    .tx_byte_o    (tx_byte_o),
    .rx_valid_o   (rx_valid_o),
    .rx_byte_o    (rx_byte_o),
    .done_res_o   (done_res_o),
    .error_code_o (error_code_o)
  );

  // sequencer state and register copies
  logic [6:0]  cfg_dev_addr = 7'd80;
  logic [1:0]  cfg_abytes   = 2'd2;
  seq_phase_e  seq_phase    = SEQ_IDLE;
  logic        seq_is_read  = 1'b0;
  logic [15:0] seq_target   = '0;
  logic [7:0]  seq_left     = '0;

  bus_item_t           pending_items[$];
  i2cmts_pkg::result_t expected_results[$];
  bus_item_t           cur_item;

  int  items_sent   = 0;
  int  results_seen = 0;
  int  failures     = 0;
  int  txn_items    = 0;
  int  transactions = 0;
  int  nacks        = 0;
  int  noise_pct    = 0;
  int  send_gap     = 0;
  int  stall_wait   = 0;
  int  hold_cycles  = 0;
  int  quiet_cycles = 0;
  bit  tx_calm      = 1'b0;
  bit  rx_calm      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic i2cmts_pkg::result_t txn_end(logic [2:0] cmd, logic [2:0] code);
    i2cmts_pkg::result_t r;
    r = '0;
    r.bus_cmd    = cmd;
    r.done_res   = 1'b1;
    r.error_code = code;
    seq_phase    = SEQ_IDLE;
    return r;
  endfunction

  function automatic i2cmts_pkg::result_t sequence_step(bus_item_t it);
    i2cmts_pkg::result_t r;
    r = '0;
    if (it.func == i2cmts_pkg::FUNC_BEGIN_RD || it.func == i2cmts_pkg::FUNC_BEGIN_WR) begin
      // a begin while a transaction is open is dropped
      if (seq_phase == SEQ_IDLE) begin
        seq_is_read = (it.func == i2cmts_pkg::FUNC_BEGIN_RD);
        seq_target  = it.maddr & ADDR_MASK;
        seq_left    = it.length;
        seq_phase   = SEQ_START;
        r.bus_cmd   = i2cmts_pkg::CMD_START;
      end
    end else if (it.func == i2cmts_pkg::FUNC_BUS_DONE) begin
      case (seq_phase)
        SEQ_IDLE: ;
        SEQ_START: begin
          r.bus_cmd = i2cmts_pkg::CMD_SEND;
          r.tx_byte = {cfg_dev_addr, i2cmts_pkg::RW_WRITE};
          seq_phase = SEQ_CTRLW;
        end
        SEQ_CTRLW: begin
          if (it.bus_status != i2cmts_pkg::ST_MT_SLA_ACK) begin
            r = txn_end(i2cmts_pkg::CMD_NONE, i2cmts_pkg::ERR_CTRLW_NACK);
          end else if (cfg_abytes[1]) begin
            r.bus_cmd = i2cmts_pkg::CMD_SEND;
            r.tx_byte = seq_target[15:8];
            seq_phase = SEQ_ADDRH;
          end else begin
            r.bus_cmd = i2cmts_pkg::CMD_SEND;
            r.tx_byte = seq_target[7:0];
            seq_phase = SEQ_ADDRL;
          end
        end
        SEQ_ADDRH: begin
          if (it.bus_status != i2cmts_pkg::ST_MT_DATA_ACK) begin
            r = txn_end(i2cmts_pkg::CMD_NONE, i2cmts_pkg::ERR_ADDRH_NACK);
          end else begin
            r.bus_cmd = i2cmts_pkg::CMD_SEND;
            r.tx_byte = seq_target[7:0];
            seq_phase = SEQ_ADDRL;
          end
        end
        SEQ_ADDRL: begin
          if (it.bus_status != i2cmts_pkg::ST_MT_DATA_ACK) begin
            r = txn_end(i2cmts_pkg::CMD_NONE, i2cmts_pkg::ERR_ADDRL_NACK);
          end else if (seq_is_read) begin
            r.bus_cmd = i2cmts_pkg::CMD_START;
            seq_phase = SEQ_RSTART;
          end else if (seq_left == 0) begin
            r = txn_end(i2cmts_pkg::CMD_STOP, i2cmts_pkg::ERR_OK);
          end else begin
            r.bus_cmd = i2cmts_pkg::CMD_SEND;
            r.tx_byte = it.wr_data;
            seq_phase = SEQ_WDATA;
          end
        end
        SEQ_WDATA: begin
          if (it.bus_status != i2cmts_pkg::ST_MT_DATA_ACK) begin
            r = txn_end(i2cmts_pkg::CMD_NONE, i2cmts_pkg::ERR_DATA_NACK);
          end else begin
            seq_left = seq_left - 8'd1;
            if (seq_left == 0) begin
              r = txn_end(i2cmts_pkg::CMD_STOP, i2cmts_pkg::ERR_OK);
            end else begin
              r.bus_cmd = i2cmts_pkg::CMD_SEND;
              r.tx_byte = it.wr_data;
            end
          end
        end
        SEQ_RSTART: begin
          r.bus_cmd = i2cmts_pkg::CMD_SEND;
          r.tx_byte = {cfg_dev_addr, i2cmts_pkg::RW_READ};
          seq_phase = SEQ_CTRLR;
        end
        SEQ_CTRLR: begin
          if (it.bus_status != i2cmts_pkg::ST_MR_SLA_ACK) begin
            r = txn_end(i2cmts_pkg::CMD_NONE, i2cmts_pkg::ERR_CTRLR_NACK);
          end else if (seq_left == 0) begin
            r = txn_end(i2cmts_pkg::CMD_STOP, i2cmts_pkg::ERR_OK);
          end else begin
            r.bus_cmd = (seq_left > 1) ? i2cmts_pkg::CMD_RXACK : i2cmts_pkg::CMD_RXNACK;
            seq_phase = SEQ_RDATA;
          end
        end
        SEQ_RDATA: begin
          // receive status is never looked at
          seq_left = seq_left - 8'd1;
          if (seq_left == 0) r = txn_end(i2cmts_pkg::CMD_STOP, i2cmts_pkg::ERR_OK);
          else r.bus_cmd = (seq_left > 1) ? i2cmts_pkg::CMD_RXACK : i2cmts_pkg::CMD_RXNACK;
          r.rx_valid = 1'b1;
          r.rx_byte  = it.bus_rx_byte;
        end
        default: seq_phase = SEQ_IDLE;
      endcase
    end
    return r;
  endfunction

  function automatic bus_item_t rand_item(logic [1:0] f);
    bus_item_t it;
    it.func        = f;
    it.maddr       = 16'($urandom);
    it.length      = 8'($urandom);
    it.wr_data     = 8'($urandom);
    it.bus_status  = 8'($urandom);
    it.bus_rx_byte = 8'($urandom);
    return it;
  endfunction

  // items the sequencer must drop: begins while open, dones while idle, unused func
  task automatic push_noise(bit open);
    logic [1:0] f;
    if ($urandom_range(0, 2) == 0) f = FUNC_UNUSED;
    else if (!open) f = i2cmts_pkg::FUNC_BUS_DONE;
    else f = $urandom_range(0, 1) ? i2cmts_pkg::FUNC_BEGIN_RD : i2cmts_pkg::FUNC_BEGIN_WR;
    pending_items.push_back(rand_item(f));
  endtask

  task automatic queue_transaction(bit rd, int len, logic [15:0] maddr, int err_at);
    bus_item_t  it;
    int         nab;
    int         total;
    int         n_checked;
    int         n_chk;
    int         err_step;
    bit         chk;
    logic [7:0] good;
    logic [7:0] bad;
    if ($urandom_range(0, 99) < noise_pct) push_noise(1'b0);
    it = rand_item(rd ? i2cmts_pkg::FUNC_BEGIN_RD : i2cmts_pkg::FUNC_BEGIN_WR);
    it.maddr  = maddr;
    it.length = 8'(len);
    pending_items.push_back(it);
    txn_items++;
    transactions++;
    nab       = cfg_abytes[1] ? 2 : 1;
    total     = rd ? (4 + nab + len) : (2 + nab + len);
    n_checked = rd ? (2 + nab) : (1 + nab + len);
    err_step  = (err_at == PICK_ERROR) ? int'($urandom_range(0, n_checked - 1)) : err_at;
    n_chk     = 0;
    for (int s = 0; s < total; s++) begin
      // start, repeated start and receive completions carry no checked status
      chk  = !(s == 0 || (rd && (s == 2 + nab || s > 3 + nab)));
      good = (s == 1) ? i2cmts_pkg::ST_MT_SLA_ACK :
             (rd && s == 3 + nab) ? i2cmts_pkg::ST_MR_SLA_ACK :
             i2cmts_pkg::ST_MT_DATA_ACK;
      if ($urandom_range(0, 99) < noise_pct) push_noise(1'b1);
      it = rand_item(i2cmts_pkg::FUNC_BUS_DONE);
      if (chk) begin
        it.bus_status = good;
        if (n_chk == err_step) begin
          bad = 8'($urandom);
          if (bad == good) bad = ~bad;
          it.bus_status = bad;
          pending_items.push_back(it);
          txn_items++;
          nacks++;
          return;
        end
        n_chk++;
      end
      pending_items.push_back(it);
      txn_items++;
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_DEVICE_ADDRESS) cfg_dev_addr = data;
    else cfg_abytes = data[1:0];
  endtask

  task automatic run_phase(logic [6:0] dev, logic [6:0] ab, bit long_read, bit long_write);
    int start_items;
    int len;
    int pick;
    bit rd;
    write_reg(REG_DEVICE_ADDRESS, dev);
    write_reg(REG_ADDRESS_BYTES, ab);
    @(negedge clk_i);
    start_items = txn_items;
    if (long_read) queue_transaction(1'b1, 255, 16'($urandom), NO_ERROR);
    if (long_write) queue_transaction(1'b0, 255, 16'($urandom), NO_ERROR);
    while (txn_items - start_items < PHASE_ITEMS) begin
      rd   = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      len  = (pick < 70) ? $urandom_range(0, 3) :
             (pick < 95) ? $urandom_range(4, 16) : $urandom_range(17, 40);
      queue_transaction(rd, len, 16'($urandom),
                        ($urandom_range(0, 3) == 0) ? PICK_ERROR : NO_ERROR);
    end
    wait_drained();
  endtask

  // input side: one transfer per accepted item, random gap before the next one
  always @(posedge clk_i or negedge rst_ni) begin : item_driver
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(sequence_step(cur_item));
        items_sent++;
        send_gap = tx_calm ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled payload
      end else if (send_gap == 0 && pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        in_valid_i    <= 1'b1;
        func_i        <= cur_item.func;
        maddr_i       <= cur_item.maddr;
        length_i      <= cur_item.length;
        wr_data_i     <= cur_item.wr_data;
        bus_status_i  <= cur_item.bus_status;
        bus_rx_byte_i <= cur_item.bus_rx_byte;
      end else begin
        if (send_gap > 0) send_gap--;
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    i2cmts_pkg::result_t got;
    i2cmts_pkg::result_t want;
    logic                stall_next;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {bus_cmd_o, tx_byte_o, rx_valid_o, rx_byte_o, done_res_o, error_code_o};
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          failures++;
        end else begin
          want = expected_results.pop_front();
          check_field("bus_cmd", 8'(want.bus_cmd), 8'(got.bus_cmd));
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("rx_valid", 8'(want.rx_valid), 8'(got.rx_valid));
          check_field("rx_byte", want.rx_byte, got.rx_byte);
          check_field("done_res", 8'(want.done_res), 8'(got.done_res));
          check_field("error_code", 8'(want.error_code), 8'(got.error_code));
        end
        stall_wait = rx_calm ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        // one long hold so the pipe fills and backs up the input
        if (results_seen == PRESSURE_AT) hold_cycles = PRESSURE_LEN;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        stall_next = 1'b1;
      end else if (stall_wait > 0) begin
        stall_wait--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall_i <= stall_next;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset register values, zero length write at top address,
    // one byte read at address zero, control and high address NACKs, dropped items
    queue_transaction(1'b0, 0, 16'hFFFF, NO_ERROR);
    queue_transaction(1'b1, 1, 16'h0000, NO_ERROR);
    queue_transaction(1'b0, 1, 16'h1234, 0);
    queue_transaction(1'b1, 0, 16'hA5C3, 1);
    pending_items.push_back(rand_item(i2cmts_pkg::FUNC_BUS_DONE));
    pending_items.push_back(rand_item(FUNC_UNUSED));
    wait_drained();

    noise_pct = 6;
    run_phase(7'h00, 7'h01, 1'b1, 1'b0);
    run_phase(7'h7F, 7'h02, 1'b0, 1'b1);
    run_phase(7'h2A, 7'h00, 1'b0, 1'b0);
    run_phase(7'h55, 7'h03, 1'b0, 1'b0);
    run_phase(7'($urandom), 7'h7D, 1'b0, 1'b0);
    run_phase(7'h50, 7'h7E, 1'b0, 1'b0);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d transactions (%0d cut short by a NACK) over six register settings",
             transactions, nacks);
    $display("%0d items sent, %0d results checked, %0d failures",
             items_sent, results_seen, failures);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
hdl/i2cmts_pkg.sv
hdl/i2cmts_out_reg.sv
hdl/i2c_memory_transaction_sequencer_top.sv
verif/i2c_memory_transaction_sequencer_top_tb.sv
